>>> design/cfr_pkg.sv
package cfr_pkg;

    localparam int MAX_ARGS = 32;
    localparam int ARG_W = $clog2(MAX_ARGS);

    localparam logic [8:0] HEADER_LEN = 9'd5;
    localparam logic [8:0] MIN_FRAME = 9'd7;
    localparam logic [8:0] COUNT_MAX = 9'd511;
    localparam logic [8:0] ARG_END = MIN_FRAME + 9'(MAX_ARGS);
    localparam logic [8:0] ARGS_LIMIT = 9'(MAX_ARGS);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_SYNC      = 4'd2,
        ST_VERSION   = 4'd3,
        ST_TYPE      = 4'd4,
        ST_LENGTH    = 4'd5,
        ST_CRC       = 4'd6,
        ST_PAY_SHORT = 4'd7,
        ST_MANY_ARGS = 4'd8,
        ST_ARG_LEN   = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        CFG_SYNC    = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_TYPE    = 2'd2
    } cfg_index_t;

    // crc-16/ccitt-false, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> design/crc16_command_frame_receiver.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   data_byte, end_of_frame
// out       output     out_valid / out_ready status, opcode, arg_count, arg_valid,
//                                            arg_index, arg_byte, last
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// one byte per cycle while a frame streams in; the end-of-frame byte is followed by
// a check state, which also loads an error or empty result; each argument result
// then goes through an argument memory read, then a load into the output register.
// input is held off from the end-of-frame byte until the last result is loaded.
// out_ready low stalls the sequence at the output register. no clearing pass after
// reset: the argument memory is only read at entries written in the same frame.
module crc16_command_frame_receiver
    import cfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_frame,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] status,
    output logic [7:0] opcode,
    output logic [5:0] arg_count,
    output logic       arg_valid,
    output logic [4:0] arg_index,
    output logic [7:0] arg_byte,
    output logic       last,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic [1:0] {
        RECV,
        CHECK,
        EMIT_RD,
        EMIT_WR
    } state_t;

    state_t     state_reg;
    logic [7:0] sync_reg;
    logic [7:0] version_reg;
    logic [7:0] type_reg;

    logic [8:0]  count_reg;
    status_t     hdr_status_reg;
    logic [7:0]  plen_reg;
    logic [7:0]  cmd_reg;
    logic [7:0]  dargs_reg;
    logic [15:0] crc_reg;
    logic [7:0]  held0_reg;
    logic [7:0]  held1_reg;
    logic [ARG_W-1:0] emit_idx_reg;

    logic       out_valid_reg;
    status_t    out_status_reg;
    logic [7:0] out_cmd_reg;
    logic [5:0] out_count_reg;
    logic       out_avalid_reg;
    logic [4:0] out_idx_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       in_fire;
    logic       out_free;
    logic       out_load;
    logic       mem_we;
    logic [ARG_W-1:0] mem_waddr;
    logic [7:0] mem_rdata;
    logic       emit_last;
    status_t    chk_status;

    assign in_ready = (state_reg == RECV);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = out_free
                      && ((state_reg == CHECK && (chk_status != ST_OK || dargs_reg == 8'd0))
                          || state_reg == EMIT_WR);

    assign mem_we    = in_fire && (count_reg >= MIN_FRAME) && (count_reg < ARG_END);
    assign mem_waddr = ARG_W'(count_reg - MIN_FRAME);
    assign emit_last = (8'(emit_idx_reg) + 8'd1) == dargs_reg;

    cfr_arg_store u_arg_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_byte),
        .re    (state_reg == EMIT_RD),
        .raddr (emit_idx_reg),
        .rdata (mem_rdata)
    );

    // first failing check wins
    always_comb
    begin
        if (count_reg < MIN_FRAME)
            chk_status = ST_SHORT;
        else if (hdr_status_reg != ST_OK)
            chk_status = hdr_status_reg;
        else if (count_reg != MIN_FRAME + {1'b0, plen_reg})
            chk_status = ST_LENGTH;
        else if ({held1_reg, held0_reg} != crc_reg)
            chk_status = ST_CRC;
        else if (plen_reg < 8'd2)
            chk_status = ST_PAY_SHORT;
        else if ({1'b0, dargs_reg} > ARGS_LIMIT)
            chk_status = ST_MANY_ARGS;
        else if ({1'b0, plen_reg} != 9'd2 + {1'b0, dargs_reg})
            chk_status = ST_ARG_LEN;
        else
            chk_status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= RECV;
            sync_reg       <= '0;
            version_reg    <= '0;
            type_reg       <= '0;
            count_reg      <= '0;
            hdr_status_reg <= ST_OK;
            plen_reg       <= '0;
            cmd_reg        <= '0;
            dargs_reg      <= '0;
            crc_reg        <= CRC_INIT;
            held0_reg      <= '0;
            held1_reg      <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_cmd_reg    <= '0;
            out_count_reg  <= '0;
            out_avalid_reg <= 1'b0;
            out_idx_reg    <= '0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC:    sync_reg <= cfg_data;
                    CFG_VERSION: version_reg <= cfg_data;
                    CFG_TYPE:    type_reg <= cfg_data;
                    default:     ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                RECV:
                begin
                    if (in_fire)
                    begin
                        // last two bytes stay out of the crc until proven not to be it
                        if (count_reg >= 9'd2)
                            crc_reg <= crc_feed(crc_reg, held0_reg);
                        held0_reg <= held1_reg;
                        held1_reg <= data_byte;

                        if (hdr_status_reg == ST_OK)
                        begin
                            if (count_reg == 9'd0 && data_byte != sync_reg)
                                hdr_status_reg <= ST_SYNC;
                            else if (count_reg == 9'd1 && data_byte != version_reg)
                                hdr_status_reg <= ST_VERSION;
                            else if (count_reg == 9'd2 && data_byte != type_reg)
                                hdr_status_reg <= ST_TYPE;
                        end
                        if (count_reg == 9'd4)
                            plen_reg <= data_byte;
                        if (count_reg == HEADER_LEN)
                            cmd_reg <= data_byte;
                        if (count_reg == HEADER_LEN + 9'd1)
                            dargs_reg <= data_byte;

                        if (count_reg < COUNT_MAX)
                            count_reg <= count_reg + 9'd1;

                        if (end_of_frame)
                            state_reg <= CHECK;
                    end
                end

                CHECK:
                begin
                    if (chk_status != ST_OK || dargs_reg == 8'd0)
                    begin
                        if (out_free)
                        begin
                            out_status_reg <= chk_status;
                            out_cmd_reg    <= (chk_status == ST_OK) ? cmd_reg : 8'd0;
                            out_count_reg  <= '0;
                            out_avalid_reg <= 1'b0;
                            out_idx_reg    <= '0;
                            out_byte_reg   <= '0;
                            out_last_reg   <= 1'b1;
                            state_reg      <= RECV;
                            count_reg      <= '0;
                            hdr_status_reg <= ST_OK;
                            plen_reg       <= '0;
                            cmd_reg        <= '0;
                            dargs_reg      <= '0;
                            crc_reg        <= CRC_INIT;
                            held0_reg      <= '0;
                            held1_reg      <= '0;
                            emit_idx_reg   <= '0;
                        end
                    end
                    else
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= EMIT_RD;
                    end
                end

                EMIT_RD:
                begin
                    state_reg <= EMIT_WR;
                end

                EMIT_WR:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= ST_OK;
                        out_cmd_reg    <= cmd_reg;
                        out_count_reg  <= dargs_reg[5:0];
                        out_avalid_reg <= 1'b1;
                        out_idx_reg    <= 5'(emit_idx_reg);
                        out_byte_reg   <= mem_rdata;
                        out_last_reg   <= emit_last;
                        if (emit_last)
                        begin
                            state_reg      <= RECV;
                            count_reg      <= '0;
                            hdr_status_reg <= ST_OK;
                            plen_reg       <= '0;
                            cmd_reg        <= '0;
                            dargs_reg      <= '0;
                            crc_reg        <= CRC_INIT;
                            held0_reg      <= '0;
                            held1_reg      <= '0;
                            emit_idx_reg   <= '0;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + ARG_W'(1);
                            state_reg    <= EMIT_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= RECV;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign opcode     = out_cmd_reg;
    assign arg_count  = out_count_reg;
    assign arg_valid  = out_avalid_reg;
    assign arg_index  = out_idx_reg;
    assign arg_byte   = out_byte_reg;
    assign last       = out_last_reg;

endmodule

>>> design/cfr_arg_store.sv
module cfr_arg_store
    import cfr_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [ARG_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic             re,
    input  logic [ARG_W-1:0] raddr,
    output logic [7:0]       rdata
);

    logic [7:0] mem [MAX_ARGS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cfr_checker.sv
module cfr_checker
    import cfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_frame,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] status,
    input logic [7:0] opcode,
    input logic [5:0] arg_count,
    input logic       arg_valid,
    input logic [4:0] arg_index,
    input logic [7:0] arg_byte,
    input logic       last
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(arg_byte)
            && $stable(arg_index) && $stable(last))
        else $error("result changed while stalled");

    // error result carries nothing else and ends the frame
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !arg_valid && opcode == 8'd0
            && arg_count == 6'd0 && arg_index == 5'd0 && arg_byte == 8'd0)
        else $error("error result not clean");

    // an argument result lies inside the declared count
    a_arg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arg_valid |-> status == ST_OK && {1'b0, arg_index} < arg_count
            && (last == ({1'b0, arg_index} + 6'd1 == arg_count)))
        else $error("argument result out of range");

    // frame end stops intake while results are formed
    a_eof_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_frame |=> !in_ready)
        else $error("byte taken right after end of frame");

endmodule

bind crc16_command_frame_receiver cfr_checker u_cfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .opcode       (opcode),
    .arg_count    (arg_count),
    .arg_valid    (arg_valid),
    .arg_index    (arg_index),
    .arg_byte     (arg_byte),
    .last         (last)
);
